// File: src/u8sd_pkg.sv
// u8sd_pkg: shared types and constants of the utf8 stream decoder
// used by every module of the decoder; depends on nothing

package u8sd_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [7:0]  LEAD2_LO       = 8'hC2;
    localparam logic [7:0]  LEAD2_HI       = 8'hDF;
    localparam logic [7:0]  LEAD3_LO       = 8'hE0;
    localparam logic [7:0]  LEAD3_HI       = 8'hEF;
    localparam logic [7:0]  LEAD4_LO       = 8'hF0;
    localparam logic [7:0]  LEAD4_HI       = 8'hF4;
    localparam logic [7:0]  MIN_AFTER_E0   = 8'hA0;
    localparam logic [7:0]  MIN_AFTER_F0   = 8'h90;
    localparam logic [7:0]  MAX_AFTER_F4   = 8'h8F;
    localparam logic [7:0]  CONT_MASK      = 8'hC0;
    localparam logic [7:0]  CONT_TAG       = 8'h80;
    localparam logic [7:0]  PAYLOAD_MASK   = 8'h3F;
    localparam logic [7:0]  ASCII_LIMIT    = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [20:0] code_point;
        logic        well_formed;
        logic [2:0]  bytes_used;
        logic        run_last;
    } t_out_word;

    // results of one byte: pre replacements, optional middle result, then the rest
    typedef struct packed {
        logic [1:0]  pre;
        logic        has_mid;
        logic [20:0] mid_cp;
        logic        mid_wf;
        logic [2:0]  mid_used;
        logic [2:0]  count;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: src/utf8_stream_decoder.sv
// utf8_stream_decoder: top level of the streaming utf-8 (wtf-8) decoder
// depends on u8sd_pkg, u8sd_front, u8sd_queue, u8sd_back
//
// Input channel: one byte per word with an end-of-text flag, taken when
// i_in_valid is high and o_in_stall is low. Output channel: one code point per
// word with well_formed, bytes_used and run_last, taken when o_out_valid is
// high and i_out_stall is low; run_last marks the last word caused by a byte.
// A byte gives 0 to 4 words: held bytes of a broken or unfinished sequence come
// out as U+FFFD replacements, one per byte, ahead of the byte's own result.
// Throughput: one byte per cycle while each byte gives at most one word and the
// receiver does not stall; the output register sends one word per cycle, so the
// words of one byte leave in turn. A four-entry group queue between the byte
// classifier and the word expander absorbs these runs; o_in_stall rises when it
// is full. A byte's first word passes the group queue and the output register.
// Reset (synchronous, active low) clears the open sequence, the queue and the
// output register. When the receiver stalls, the output word holds, the queue
// fills and then the input is stalled; nothing is dropped.

module utf8_stream_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  u8sd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output u8sd_pkg::t_out_word o_out_word
);

    u8sd_pkg::t_q_status q_status;
    u8sd_pkg::t_group    grp;
    u8sd_pkg::t_group    head;
    logic                grp_valid;
    logic                in_accept;
    logic                pop;

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    u8sd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_word      (i_in_word),
        .o_grp_valid (grp_valid),
        .o_grp       (grp)
    );

    u8sd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (grp_valid),
        .i_grp    (grp),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    u8sd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (q_status),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// File: src/u8sd_front.sv
// u8sd_front: sequence tracking and classification of input bytes
// depends on u8sd_pkg; emits one result group per byte that gives results

module u8sd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  u8sd_pkg::t_in_word i_word,
    output logic              o_grp_valid,
    output u8sd_pkg::t_group  o_grp
);

    logic [1:0]  r_held, n_held;
    logic [1:0]  r_need, n_need;
    logic [7:0]  r_lead, n_lead;
    logic [20:0] r_bits, n_bits;

    always_comb begin
        logic [7:0]  b;
        logic        cont_ok;
        logic [20:0] ext_bits;
        logic [2:0]  total;
        logic [1:0]  post;
        logic        opened;
        b        = i_word.in_byte;
        n_held   = r_held;
        n_need   = r_need;
        n_lead   = r_lead;
        n_bits   = r_bits;
        post     = 2'd0;
        opened   = 1'b0;
        o_grp    = '0;
        cont_ok  = (b & u8sd_pkg::CONT_MASK) == u8sd_pkg::CONT_TAG;
        if (r_held == 2'd1) begin
            if (r_lead == u8sd_pkg::LEAD3_LO && b < u8sd_pkg::MIN_AFTER_E0) cont_ok = 1'b0;
            if (r_lead == u8sd_pkg::LEAD4_LO && b < u8sd_pkg::MIN_AFTER_F0) cont_ok = 1'b0;
            if (r_lead == u8sd_pkg::LEAD4_HI && b > u8sd_pkg::MAX_AFTER_F4) cont_ok = 1'b0;
        end
        ext_bits = {r_bits[14:0], b[5:0]};
        total    = {1'b0, r_held} + 3'd1;
        if (r_held != 2'd0 && cont_ok) begin
            if (total == {1'b0, r_need} + 3'd1) begin
                o_grp.has_mid  = 1'b1;
                o_grp.mid_cp   = ext_bits;
                o_grp.mid_wf   = 1'b1;
                o_grp.mid_used = total;
                n_held = 2'd0;
                n_need = 2'd0;
                n_lead = 8'd0;
                n_bits = 21'd0;
            end else begin
                n_held = total[1:0];
                n_bits = ext_bits;
            end
        end else begin
            o_grp.pre = r_held;
            n_held = 2'd0;
            n_need = 2'd0;
            n_lead = 8'd0;
            n_bits = 21'd0;
            if (b < u8sd_pkg::ASCII_LIMIT) begin
                o_grp.has_mid  = 1'b1;
                o_grp.mid_cp   = {13'd0, b};
                o_grp.mid_wf   = 1'b1;
                o_grp.mid_used = 3'd1;
            end else if (b >= u8sd_pkg::LEAD2_LO && b <= u8sd_pkg::LEAD2_HI) begin
                opened = 1'b1;
                n_need = 2'd1;
                n_bits = {16'd0, b[4:0]};
            end else if (b >= u8sd_pkg::LEAD3_LO && b <= u8sd_pkg::LEAD3_HI) begin
                opened = 1'b1;
                n_need = 2'd2;
                n_bits = {17'd0, b[3:0]};
            end else if (b >= u8sd_pkg::LEAD4_LO && b <= u8sd_pkg::LEAD4_HI) begin
                opened = 1'b1;
                n_need = 2'd3;
                n_bits = {18'd0, b[2:0]};
            end else begin
                o_grp.has_mid  = 1'b1;
                o_grp.mid_cp   = u8sd_pkg::CP_REPLACEMENT;
                o_grp.mid_wf   = 1'b0;
                o_grp.mid_used = 3'd1;
            end
            if (opened) begin
                n_held = 2'd1;
                n_lead = b;
            end
        end
        // open sequence at end of text flushes one replacement per held byte
        if (i_word.end_of_text && n_held != 2'd0) begin
            post   = n_held;
            n_held = 2'd0;
            n_need = 2'd0;
            n_lead = 8'd0;
            n_bits = 21'd0;
        end
        o_grp.count = {1'b0, o_grp.pre} + {2'b0, o_grp.has_mid} + {1'b0, post};
        o_grp_valid = i_accept && (o_grp.count != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 2'd0;
            r_need <= 2'd0;
            r_lead <= 8'd0;
            r_bits <= 21'd0;
        end else if (i_accept) begin
            r_held <= n_held;
            r_need <= n_need;
            r_lead <= n_lead;
            r_bits <= n_bits;
        end
    end

endmodule

// File: src/u8sd_queue.sv
// u8sd_queue: short register queue of result groups between front and back
// depends on u8sd_pkg

module u8sd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  u8sd_pkg::t_group    i_grp,
    input  logic                i_pop,
    output u8sd_pkg::t_group    o_head,
    output u8sd_pkg::t_q_status o_status
);

    u8sd_pkg::t_group r_mem [u8sd_pkg::QDEPTH];

    logic [u8sd_pkg::QAW-1:0] r_wr, r_rd;
    logic [u8sd_pkg::QAW:0]   r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_grp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = r_cnt == (u8sd_pkg::QAW + 1)'(u8sd_pkg::QDEPTH);
    assign o_status.empty = r_cnt == '0;

endmodule

// File: src/u8sd_back.sv
// u8sd_back: expands queued result groups into words and holds the output register
// depends on u8sd_pkg

module u8sd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u8sd_pkg::t_group    i_head,
    input  u8sd_pkg::t_q_status i_status,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output u8sd_pkg::t_out_word o_out_word
);

    logic [1:0]          r_idx;
    logic                r_valid;
    u8sd_pkg::t_out_word r_word, n_word;
    logic                load;
    logic                is_mid;
    logic                is_last;

    assign load    = !i_status.empty && (!r_valid || !i_out_stall);
    assign is_mid  = i_head.has_mid && (r_idx == i_head.pre);
    assign is_last = {1'b0, r_idx} == (i_head.count - 3'd1);
    assign o_pop   = load && is_last;

    always_comb begin
        n_word.code_point  = is_mid ? i_head.mid_cp   : u8sd_pkg::CP_REPLACEMENT;
        n_word.well_formed = is_mid ? i_head.mid_wf   : 1'b0;
        n_word.bytes_used  = is_mid ? i_head.mid_used : 3'd1;
        n_word.run_last    = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_word <= n_word;
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

// File: src/u8sd_checker.sv
// u8sd_checker: port-level assertions for the utf8 stream decoder, bound to the top
// depends on u8sd_pkg and utf8_stream_decoder

module u8sd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input u8sd_pkg::t_out_word o_out_word
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_bad_is_replacement: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.well_formed |->
            o_out_word.code_point == u8sd_pkg::CP_REPLACEMENT
            && o_out_word.bytes_used == 3'd1)
        else $error("replacement word malformed");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.bytes_used != 3'd0 && o_out_word.bytes_used <= 3'd4
            && (o_out_word.bytes_used != 3'd1 || o_out_word.code_point < 21'h80
                || !o_out_word.well_formed))
        else $error("bytes_used out of range");

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
